/* rtl/core/qpd_pkg.sv */
// Package for the quoted-printable decoder.
// Holds the mode encoding, the character codes, the result types and the hex helper.
// No dependencies.
package qpd_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_HEX    = 3'd2,
		MODE_SOFT   = 3'd3,
		MODE_STOP   = 3'd4
	} mode_t;

	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

	// Bit 4 of a hex lookup marks a byte that is not a hex digit.
	localparam logic [4:0] HEX_NONE = 5'h10;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned PtrW      = $clog2(FifoDepth);
	localparam int unsigned LevelW    = $clog2(FifoDepth + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} result_t;

	// Up to two results from one input beat.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} pair_t;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			v = {1'b0, c[3:0] + 4'd9};
		return v;
	endfunction

	function automatic logic is_crlf(input logic [7:0] c);
		return (c == CH_CR) || (c == CH_LF);
	endfunction

endpackage

/* rtl/core/qpd_decode.sv */
// Decode step of the quoted-printable decoder: mode and nibble registers plus the
// combinational logic that turns one registered input byte into up to two results.
// Depends on qpd_pkg.
module qpd_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic [7:0]     byte_s1,
	input  logic           final_s1,
	output qpd_pkg::pair_t pair
);
	import qpd_pkg::*;

	mode_t      mode_q, mode_d;
	logic [3:0] nib_q, nib_d;
	logic [4:0] hv;
	logic       is_hex;
	logic [1:0] cnt;
	result_t    r0, r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			nib_q  <= 4'd0;
		end else if (advance) begin
			mode_q <= mode_d;
			nib_q  <= nib_d;
		end
	end

	always_comb begin
		hv     = hex_value(byte_s1);
		is_hex = !hv[4];
		mode_d = mode_q;
		nib_d  = nib_q;
		cnt    = 2'd0;
		r0     = '{data: 8'd0, has_byte: 1'b0, eom: 1'b0};
		r1     = '{data: 8'd0, has_byte: 1'b0, eom: 1'b0};

		case (mode_q)
			MODE_STOP: begin
			end
			MODE_ESC: begin
				if (byte_s1 == CH_NUL) begin
					mode_d = MODE_STOP;
				end else if (final_s1) begin
					mode_d = MODE_NORMAL;
				end else if (is_hex) begin
					nib_d  = hv[3:0];
					mode_d = MODE_HEX;
				end else if (is_crlf(byte_s1)) begin
					mode_d = MODE_SOFT;
				end else begin
					// Not a valid escape: the equals sign goes out literally.
					r0     = '{data: CH_EQ, has_byte: 1'b1, eom: 1'b0};
					r1     = '{data: byte_s1, has_byte: 1'b1, eom: 1'b0};
					cnt    = 2'd2;
					mode_d = MODE_NORMAL;
				end
			end
			MODE_HEX: begin
				if (byte_s1 == CH_NUL) begin
					mode_d = MODE_STOP;
				end else begin
					if (is_hex) begin
						r0  = '{data: {nib_q, hv[3:0]}, has_byte: 1'b1, eom: 1'b0};
						cnt = 2'd1;
					end else if (is_crlf(byte_s1)) begin
						r0  = '{data: byte_s1, has_byte: 1'b1, eom: 1'b0};
						cnt = 2'd1;
					end
					mode_d = MODE_NORMAL;
				end
			end
			default: begin
				// Normal mode, the end of a soft break, and unused codes.
				if (mode_q == MODE_SOFT && is_crlf(byte_s1)) begin
					mode_d = MODE_SOFT;
				end else if (byte_s1 == CH_NUL) begin
					mode_d = MODE_STOP;
				end else if (byte_s1 == CH_EQ) begin
					mode_d = MODE_ESC;
				end else begin
					r0     = '{data: byte_s1, has_byte: 1'b1, eom: 1'b0};
					cnt    = 2'd1;
					mode_d = MODE_NORMAL;
				end
			end
		endcase

		if (final_s1) begin
			case (cnt)
				2'd0: begin
					r0  = '{data: 8'd0, has_byte: 1'b0, eom: 1'b1};
					cnt = 2'd1;
				end
				2'd1:    r0.eom = 1'b1;
				default: r1.eom = 1'b1;
			endcase
			mode_d = MODE_NORMAL;
			nib_d  = 4'd0;
		end

		pair = '{cnt: cnt, r0: r0, r1: r1};
	end

endmodule

/* rtl/core/qpd_out_fifo.sv */
// Result queue of the quoted-printable decoder: takes up to two results per
// cycle and presents one registered result per cycle. Depends on qpd_pkg.
module qpd_out_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  qpd_pkg::pair_t             pair,
	input  logic                       rd_en,
	output qpd_pkg::result_t           head,
	output logic                       not_empty,
	output logic [qpd_pkg::LevelW-1:0] level
);
	import qpd_pkg::*;

	result_t         mem_q [FifoDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [LevelW-1:0] level_q, wr_num, rd_num;

	assign wr_ptr_1  = wr_ptr_q + PtrW'(1);
	assign wr_num    = wr_en ? LevelW'(pair.cnt) : '0;
	assign rd_num    = rd_en ? LevelW'(1) : '0;
	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (wr_en && pair.cnt != 2'd0) mem_q[wr_ptr_q] <= pair.r0;
		if (wr_en && pair.cnt == 2'd2) mem_q[wr_ptr_1] <= pair.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(wr_num);
			rd_ptr_q <= rd_ptr_q + PtrW'(rd_num);
			level_q  <= level_q + wr_num - rd_num;
		end
	end

endmodule

/* rtl/core/quoted_printable_decoder.sv */
// Top level of the quoted-printable decoder: input register, decode step and result queue.
// Depends on qpd_pkg, qpd_decode and qpd_out_fifo.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------
//   input   | in_valid / in_ready  | in_byte[7:0], is_final
//   output  | out_valid / out_ready| out_byte[7:0], has_byte, end_of_message
//
// One input beat is taken per cycle while in_ready is high. A beat is registered,
// then decoded, and its results land in a four-entry queue that drives the output.
// A beat that yields two results (an invalid escape) leaves the queue as two
// separate results, so the sustained rate is one beat per cycle while beats
// yield at most one result each and the output keeps up. The input register
// advances only when the queue has room for two results, so a stalled output
// backs up into in_ready once the queue holds more than two results.
// Reset clears the decode mode, the held nibble and the queue.
module quoted_printable_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       end_of_message
);
	import qpd_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              final_s1;
	logic              advance;
	logic              room;
	pair_t             pair;
	result_t           head;
	logic [LevelW-1:0] level;

	// The queue must hold two fresh results on top of what it already has.
	assign room     = (level <= LevelW'(FifoDepth - 2));
	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload register needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			final_s1 <= is_final;
		end
	end

	qpd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.byte_s1  (byte_s1),
		.final_s1 (final_s1),
		.pair     (pair)
	);

	qpd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance),
		.pair      (pair),
		.rd_en     (out_valid && out_ready),
		.head      (head),
		.not_empty (out_valid),
		.level     (level)
	);

	assign out_byte       = head.data;
	assign has_byte       = head.has_byte;
	assign end_of_message = head.eom;

`ifndef NO_ASSERTIONS
	// The queue never overflows.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LevelW'(FifoDepth))
		else $error("result queue level beyond its depth");

	// A result without data is only ever the bare end marker.
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> end_of_message && out_byte == 8'd0)
		else $error("empty result that is not an end marker");

	// A decoded beat always finds room for both of its results.
	a_room_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> level <= LevelW'(FifoDepth))
		else $error("queue filled past its depth after a decode");
`endif

endmodule
